>>> design/cdq_pkg.sv
package cdq_pkg;

    localparam int CAPACITY = 128;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK       = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

endpackage

>>> design/circular_deque.sv
// circular_deque: double-ended queue of 32-bit values in a circular store.
// Results: the result of a transaction accepted at edge k is registered and
// shown, with o_valid high, in the cycle after edge k; the receiver cannot stall.
// Throughput: one transaction per cycle; busy stays low, since a pointer update
// and one store write finish at the accept edge and the store reads register once.
// Reset (i_rst_n low, synchronous): empty deque, head and tail 0, capacity 128.
module circular_deque (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cdq_pkg::OP_W-1:0]          i_op,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_push_value,
    input  logic                              i_cfg_wr_en,
    input  logic [cdq_pkg::CFG_W-1:0]         i_cfg_wr_data,
    output logic                              o_valid,
    output logic signed [cdq_pkg::DATA_W-1:0] o_front_value,
    output logic signed [cdq_pkg::DATA_W-1:0] o_rear_value,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic [cdq_pkg::STATUS_W-1:0]      o_status
);

    localparam int PTR_W  = cdq_pkg::PTR_W;
    localparam int DATA_W = cdq_pkg::DATA_W;

    // Pointer state. r_cap_m1 holds the effective capacity minus one, so the
    // wrap test is a plain equality against the last usable index.
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [PTR_W-1:0]  r_cap_m1, n_cap_m1;

    // Result stage
    logic              r_valid;
    logic              r_res_empty, n_res_empty;
    logic              r_res_full, n_res_full;
    cdq_pkg::t_status  r_status, n_status;
    logic              r_fwd_front, n_fwd_front;
    logic              r_fwd_rear, n_fwd_rear;
    logic [DATA_W-1:0] r_fwd_data;

    // Store write port
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [DATA_W-1:0] rd_front;
    logic [DATA_W-1:0] rd_rear;

    logic              accept;
    logic              cur_full;
    logic [PTR_W-1:0]  tail_inc;
    logic [PTR_W-1:0]  tail_dec;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  head_dec;
    logic [PTR_W-1:0]  n_tail_inc;

    // Every transaction completes at its accept edge.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Circular neighbors of the current pointers under the active capacity
    assign tail_inc = (r_tail == r_cap_m1) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? r_cap_m1 : r_tail - 1'b1;
    assign head_inc = (r_head == r_cap_m1) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? r_cap_m1 : r_head - 1'b1;

    assign cur_full = !r_empty && (tail_inc == r_head);

    // Operation decode: new pointers, store write, status
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = cdq_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = '0;
        unique case (i_op)
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
                if (cur_full) begin
                    n_status = cdq_pkg::ST_OVERFLOW;
                end else if (r_empty) begin
                    // first entry always lands at index 0
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                    wr_addr = '0;
                end else if (i_op == cdq_pkg::OP_PUSH_FRONT) begin
                    n_head  = head_dec;
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                end else begin
                    n_tail  = tail_inc;
                    wr_en   = 1'b1;
                    wr_addr = tail_inc;
                end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
                if (r_empty) begin
                    n_status = cdq_pkg::ST_UNDERFLOW;
                end else if (r_head == r_tail) begin
                    // last entry removed: pointers return home
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (i_op == cdq_pkg::OP_POP_FRONT) begin
                    n_head = head_inc;
                end else begin
                    n_tail = tail_dec;
                end
            end
            default: begin
                // peek, and unused codes behave as peek
            end
        endcase
        if (!accept) begin
            wr_en = 1'b0;
        end
    end

    // Flags after the operation; forwarding covers a read of the entry
    // being written in the same cycle.
    assign n_tail_inc = (n_tail == r_cap_m1) ? '0 : n_tail + 1'b1;

    always_comb begin
        n_res_empty = n_empty;
        n_res_full  = !n_empty && (n_tail_inc == n_head);
        n_fwd_front = wr_en && (wr_addr == n_head);
        n_fwd_rear  = wr_en && (wr_addr == n_tail);
    end

    // Capacity register: zero maps to one, anything above the store size to
    // the store size.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_cap_m1 = '0;
        end else if (32'(i_cfg_wr_data) >= cdq_pkg::CAPACITY) begin
            n_cap_m1 = PTR_W'(cdq_pkg::CAPACITY - 1);
        end else begin
            n_cap_m1 = PTR_W'(i_cfg_wr_data - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_cap_m1 <= PTR_W'(cdq_pkg::CAPACITY - 1);
            r_valid  <= 1'b0;
        end else begin
            r_valid <= accept;
            if (i_cfg_wr_en) begin
                // new modulus: stored positions lose meaning, so empty out
                r_cap_m1 <= n_cap_m1;
                r_head   <= '0;
                r_tail   <= '0;
                r_empty  <= 1'b1;
            end else if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_empty <= n_empty;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_empty <= n_res_empty;
            r_res_full  <= n_res_full;
            r_status    <= n_status;
            r_fwd_front <= n_fwd_front;
            r_fwd_rear  <= n_fwd_rear;
            r_fwd_data  <= i_push_value;
        end
    end

    // Entry store; port A follows the front, port B the rear.
    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (cdq_pkg::CAPACITY)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_push_value),
        .i_rd_addr_a (n_head),
        .i_rd_addr_b (n_tail),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_rear)
    );

    assign o_valid       = r_valid;
    assign o_is_empty    = r_res_empty;
    assign o_is_full     = r_res_full;
    assign o_status      = r_status;
    assign o_front_value = r_res_empty ? '0 : (r_fwd_front ? r_fwd_data : rd_front);
    assign o_rear_value  = r_res_empty ? '0 : (r_fwd_rear ? r_fwd_data : rd_rear);

endmodule

>>> design/cdq_ram.sv
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // read-before-write: a same-cycle read returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data_a <= r_mem[i_rd_addr_a];
        r_rd_data_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

>>> design/cdq_checker.sv
module cdq_assertions (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [cdq_pkg::DATA_W-1:0] o_front_value,
    input logic signed [cdq_pkg::DATA_W-1:0] o_rear_value,
    input logic                              o_is_empty,
    input logic                              o_is_full,
    input logic [cdq_pkg::STATUS_W-1:0]      o_status
);

    // one result per transaction, in the following cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(start && !busy)) |-> o_valid)
        else $error("transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(start && !busy) |-> !o_valid)
        else $error("result without transaction");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_front_value == '0 && o_rear_value == '0 && !o_is_full))
        else $error("empty deque shows data or full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cdq_pkg::ST_UNDERFLOW) |-> o_is_empty)
        else $error("underflow on non-empty deque");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cdq_pkg::ST_OVERFLOW) |-> o_is_full)
        else $error("overflow on non-full deque");

endmodule

bind circular_deque cdq_assertions u_cdq_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_front_value (o_front_value),
    .o_rear_value  (o_rear_value),
    .o_is_empty    (o_is_empty),
    .o_is_full     (o_is_full),
    .o_status      (o_status)
);
